// ===== hw/rtl/dur_pkg.sv =====
// ----------------------------------------------------------------------------
// dur_pkg
// Shared constants and controller/datapath interface types for the dual
// ultrasonic ranger core.
// ----------------------------------------------------------------------------
`default_nettype none

package dur_pkg;

	// Default echo counter width
	localparam int CountWidthDef = 16;

	// Field widths
	localparam int TpuWidth     = 10;
	localparam int TrigWidth    = 8;
	localparam int SettleWidth  = 8;
	localparam int PreWidth     = 16;
	localparam int CfgDataWidth = 16;
	localparam int CfgIdxWidth  = 2;
	localparam int DistWidth    = 16;
	localparam int InWidth      = 8;
	localparam int OutWidth     = 24;

	// Register reset values
	localparam logic [TpuWidth-1:0]    TpuReset    = 10'd148;
	localparam logic [TrigWidth-1:0]   TrigReset   = 8'd12;
	localparam logic [SettleWidth-1:0] SettleReset = 8'd20;
	localparam logic [PreWidth-1:0]    PreReset    = 16'd1000;

	// Register indexes
	localparam logic [CfgIdxWidth-1:0] RegTicksPerUnit = 2'd0;
	localparam logic [CfgIdxWidth-1:0] RegTriggerHigh  = 2'd1;
	localparam logic [CfgIdxWidth-1:0] RegSettle       = 2'd2;
	localparam logic [CfgIdxWidth-1:0] RegPreTrigger   = 2'd3;

	// Commands from controller to datapath
	typedef struct packed {
		logic step;       // apply the accepted tick
		logic div_start;  // start the echo divide
		logic load_out;   // move the result into the output register
	} dur_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic needs_div;  // the offered tick ends an echo
		logic div_done;   // divide result is ready
	} dur_status_t;

	// One result transaction
	typedef struct packed {
		logic                 busy_res;
		logic [DistWidth-1:0] distance_units;
		logic                 reading_sensor;
		logic                 reading_valid;
		logic                 trigger_left;
		logic                 trigger_right;
	} dur_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dur_div.sv =====
// ----------------------------------------------------------------------------
// dur_div
// Restoring divider, one quotient bit per cycle. Divides the echo tick count
// by ticks_per_unit and saturates the quotient to 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module dur_div #(
	parameter int COUNT_WIDTH = dur_pkg::CountWidthDef
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [COUNT_WIDTH-1:0]           dividend,
	input  wire logic [dur_pkg::TpuWidth-1:0]     divisor,
	output logic                                  done,
	output logic [dur_pkg::DistWidth-1:0]         quotient
);

	localparam int CntW = $clog2(COUNT_WIDTH + 1);
	localparam int Tw   = dur_pkg::TpuWidth;
	localparam int Dw   = dur_pkg::DistWidth;

	logic [CntW-1:0]        cnt_q;
	logic [COUNT_WIDTH-1:0] work_q;
	logic [Tw-1:0]          rem_q;
	logic [Tw-1:0]          dvsr_q;
	logic                   done_q;

	logic [Tw:0]                trial;
	logic [Tw:0]                diff;
	logic                       ge;
	logic [COUNT_WIDTH+Dw-1:0]  quo_ext;
	logic                       sat;

	// Trial subtract of the next dividend bit
	assign trial = {rem_q, work_q[COUNT_WIDTH-1]};
	assign diff  = trial - {1'b0, dvsr_q};
	assign ge    = (trial >= {1'b0, dvsr_q});

	// Iterate one bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CntW'(COUNT_WIDTH);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift dividend out and quotient in
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dvsr_q <= divisor;
		end else if (cnt_q != '0) begin
			work_q <= {work_q[COUNT_WIDTH-2:0], ge};
			rem_q  <= ge ? diff[Tw-1:0] : trial[Tw-1:0];
		end
	end

	// Saturate and handle zero divisor
	assign quo_ext = {{Dw{1'b0}}, work_q};
	assign sat     = ((work_q >> Dw) != '0);
	assign done    = done_q;

	always_comb begin
		if (dvsr_q == '0 || sat) begin
			quotient = '1;
		end else begin
			quotient = quo_ext[Dw-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/dur_datapath.sv =====
// ----------------------------------------------------------------------------
// dur_datapath
// Configuration registers, ranging phase sequencer counters, echo timer,
// divider and the result/output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module dur_datapath #(
	parameter int COUNT_WIDTH = dur_pkg::CountWidthDef
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [dur_pkg::CfgIdxWidth-1:0]    cfg_index,
	input  wire logic [dur_pkg::CfgDataWidth-1:0]   cfg_wdata,
	input  wire logic                               echo_right,
	input  wire logic                               echo_left,
	input  wire logic                               start_request,
	input  wire dur_pkg::dur_cmd_t                  cmd,
	output dur_pkg::dur_status_t                    status,
	output dur_pkg::dur_result_t                    out_data
);

	localparam int Pw = dur_pkg::PreWidth;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_PRE     = 3'd1,
		PH_SETTLE1 = 3'd2,
		PH_PULSE   = 3'd3,
		PH_SETTLE2 = 3'd4,
		PH_RISE    = 3'd5,
		PH_MEASURE = 3'd6
	} phase_t;

	logic [dur_pkg::TpuWidth-1:0]    tpu_q;
	logic [dur_pkg::TrigWidth-1:0]   trig_q;
	logic [dur_pkg::SettleWidth-1:0] settle_q;
	logic [Pw-1:0]                   pre_q;

	phase_t                 phase_q;
	logic                   cur_q;
	logic [Pw-1:0]          ticks_q;
	logic [COUNT_WIDTH-1:0] echo_ticks_q;

	dur_pkg::dur_result_t res_q;
	dur_pkg::dur_result_t out_q;

	phase_t                 phase_d;
	logic                   cur_d;
	logic [Pw-1:0]          ticks_d;
	logic [COUNT_WIDTH-1:0] echo_ticks_d;
	phase_t                 enter_pre;
	phase_t                 enter_s2;
	logic [Pw-1:0]          len;
	logic                   len_hit;
	logic                   echo;
	logic                   fall;
	logic                   div_done;
	logic [dur_pkg::DistWidth-1:0] div_quo;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q    <= dur_pkg::TpuReset;
			trig_q   <= dur_pkg::TrigReset;
			settle_q <= dur_pkg::SettleReset;
			pre_q    <= dur_pkg::PreReset;
		end else if (cfg_we) begin
			case (cfg_index)
				dur_pkg::RegTicksPerUnit: tpu_q    <= cfg_wdata[dur_pkg::TpuWidth-1:0];
				dur_pkg::RegTriggerHigh:  trig_q   <= cfg_wdata[dur_pkg::TrigWidth-1:0];
				dur_pkg::RegSettle:       settle_q <= cfg_wdata[dur_pkg::SettleWidth-1:0];
				dur_pkg::RegPreTrigger:   pre_q    <= cfg_wdata[Pw-1:0];
				default: ;
			endcase
		end
	end

	// Phase entry with zero-length phases skipped
	assign enter_pre = (pre_q != '0) ? PH_PRE : ((settle_q != '0) ? PH_SETTLE1 : PH_PULSE);
	assign enter_s2  = (settle_q != '0) ? PH_SETTLE2 : PH_RISE;

	// Length of the current timed phase
	always_comb begin
		case (phase_q)
			PH_PRE:     len = pre_q;
			PH_SETTLE1: len = Pw'(settle_q);
			PH_PULSE:   len = (trig_q == '0) ? Pw'(1) : Pw'(trig_q);
			PH_SETTLE2: len = Pw'(settle_q);
			default:    len = '0;
		endcase
	end

	assign len_hit = (({1'b0, ticks_q} + (Pw+1)'(1)) >= {1'b0, len});
	assign echo    = cur_q ? echo_left : echo_right;
	assign fall    = (phase_q == PH_MEASURE) && !echo;

	// Next ranging state for one tick
	always_comb begin
		phase_d      = phase_q;
		cur_d        = cur_q;
		ticks_d      = ticks_q;
		echo_ticks_d = echo_ticks_q;
		case (phase_q)
			PH_PRE: begin
				ticks_d = ticks_q + Pw'(1);
				if (len_hit) begin
					phase_d = (settle_q != '0) ? PH_SETTLE1 : PH_PULSE;
					ticks_d = '0;
				end
			end
			PH_SETTLE1: begin
				ticks_d = ticks_q + Pw'(1);
				if (len_hit) begin
					phase_d = PH_PULSE;
					ticks_d = '0;
				end
			end
			PH_PULSE: begin
				ticks_d = ticks_q + Pw'(1);
				if (len_hit) begin
					phase_d = enter_s2;
					ticks_d = '0;
				end
			end
			PH_SETTLE2: begin
				ticks_d = ticks_q + Pw'(1);
				if (len_hit) begin
					phase_d = PH_RISE;
					ticks_d = '0;
				end
			end
			PH_RISE: begin
				if (echo) begin
					echo_ticks_d = COUNT_WIDTH'(1);
					phase_d      = PH_MEASURE;
				end
			end
			PH_MEASURE: begin
				if (echo) begin
					if (echo_ticks_q != '1) begin
						echo_ticks_d = echo_ticks_q + COUNT_WIDTH'(1);
					end
				end else if (!cur_q) begin
					cur_d   = 1'b1;
					phase_d = enter_pre;
					ticks_d = '0;
				end else begin
					cur_d   = 1'b0;
					phase_d = PH_IDLE;
					ticks_d = '0;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (start_request) begin
					cur_d   = 1'b0;
					phase_d = enter_pre;
					ticks_d = '0;
				end
			end
		endcase
	end

	// Advance ranging state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			cur_q        <= 1'b0;
			ticks_q      <= '0;
			echo_ticks_q <= '0;
		end else if (cmd.step) begin
			phase_q      <= phase_d;
			cur_q        <= cur_d;
			ticks_q      <= ticks_d;
			echo_ticks_q <= echo_ticks_d;
		end
	end

	dur_div #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (echo_ticks_q),
		.divisor  (tpu_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Capture the tick result, then fill in the distance
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			res_q.trigger_right  <= (phase_q == PH_PULSE) && !cur_q;
			res_q.trigger_left   <= (phase_q == PH_PULSE) && cur_q;
			res_q.reading_valid  <= fall;
			res_q.reading_sensor <= fall && cur_q;
			res_q.distance_units <= '0;
			res_q.busy_res       <= (phase_d != PH_IDLE);
		end else if (div_done) begin
			res_q.distance_units <= div_quo;
		end
	end

	// Hold the output transaction
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	assign status.needs_div = fall;
	assign status.div_done  = div_done;
	assign out_data         = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dur_ctrl.sv =====
// ----------------------------------------------------------------------------
// dur_ctrl
// Controller: accepts one tick at a time, sequences the divide when an echo
// ends, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dur_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	input  wire dur_pkg::dur_status_t status,
	output dur_pkg::dur_cmd_t         cmd
);

	typedef enum logic [1:0] {
		ST_WAIT = 2'd0,
		ST_DIV  = 2'd1,
		ST_PUSH = 2'd2
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   accept;
	logic   slot_free;

	assign s_tready  = (state_q == ST_WAIT);
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !m_tvalid_q || m_tready;

	// Decode commands from state
	always_comb begin
		cmd.step      = accept;
		cmd.div_start = accept && status.needs_div;
		cmd.load_out  = (state_q == ST_PUSH) && slot_free;
	end

	// Hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_WAIT;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_WAIT: begin
					if (accept) begin
						state_q <= status.needs_div ? ST_DIV : ST_PUSH;
					end
				end
				ST_DIV: begin
					if (status.div_done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (slot_free) begin
						state_q <= ST_WAIT;
					end
				end
				default: state_q <= ST_WAIT;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dual_ultrasonic_ranger_core.sv =====
// ----------------------------------------------------------------------------
// dual_ultrasonic_ranger_core
// Dual HC-SR04 style ranger: one input transaction per microsecond tick, one
// result transaction per tick with trigger levels and distance readings.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  s_*      in   tick: echo levels and start request
//  m_*      out  trigger levels, reading, distance, busy
//  cfg_*    in   register write (index 0..3)
//
// A tick is registered as a result when it is accepted and moves to the output
// register in the push state, after which the next tick is accepted; a tick on
// which an echo falls first waits in the divide state for the bit-serial
// divider. The next tick is accepted while a result waits in the output
// register; a stalled output then holds the block in its push state.
// Reset clears the phase sequencer and loads register defaults.
`default_nettype none

module dual_ultrasonic_ranger_core #(
	parameter int COUNT_WIDTH = dur_pkg::CountWidthDef
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// [0] echo_right, [1] echo_left, [2] start_request, [7:3] zero
	input  wire logic [dur_pkg::InWidth-1:0]      s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [0] trigger_right, [1] trigger_left, [2] reading_valid,
	// [3] reading_sensor, [19:4] distance_units, [20] busy_res, [23:21] zero
	output logic [dur_pkg::OutWidth-1:0]          m_tdata,
	input  wire logic                             cfg_we,
	input  wire logic [dur_pkg::CfgIdxWidth-1:0]  cfg_index,
	input  wire logic [dur_pkg::CfgDataWidth-1:0] cfg_wdata
);

	dur_pkg::dur_cmd_t    cmd;
	dur_pkg::dur_status_t status;
	dur_pkg::dur_result_t out_data;

	dur_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	dur_datapath #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.echo_right    (s_tdata[0]),
		.echo_left     (s_tdata[1]),
		.start_request (s_tdata[2]),
		.cmd           (cmd),
		.status        (status),
		.out_data      (out_data)
	);

	// Pack the result transaction
	assign m_tdata = {3'b000, out_data};

endmodule

`default_nettype wire
